@@ sv/okvt_pkg.sv @@
// Package for the ordered key/value table.
// Holds request kind codes, field widths and the per-cell control struct.
package okvt_pkg;

    localparam int FIELD_W = 32;
    localparam int KIND_W  = 3;
    localparam int POS_W   = 4;
    localparam int COUNT_W = 5;

    typedef enum logic [KIND_W-1:0] {
        K_CONTAINS    = 3'd0,
        K_INSERT      = 3'd1,
        K_UPDATE      = 3'd2,
        K_INSERT_UPD  = 3'd3,
        K_ERASE       = 3'd4,
        K_GET_KEY     = 3'd5,
        K_GET_POS     = 3'd6,
        K_CLEAR       = 3'd7
    } t_kind;

    // Commands broadcast from the sequencer to every cell.
    typedef struct packed {
        logic cmp;     // compare stored key against request key
        logic upd;     // matching cell takes the request value
        logic app;     // cell at the fill point takes key and value
        logic ers;     // cells at or above the erased slot take their neighbor
    } t_cell_ctrl;

endpackage

@@ sv/okvt_req_if.sv @@
// Request channel of the ordered key/value table.
// Depends on okvt_pkg for field widths.
interface okvt_req_if;
    logic                          valid;
    logic                          ready;
    logic [okvt_pkg::KIND_W-1:0]   kind;
    logic [okvt_pkg::FIELD_W-1:0]  req_key;
    logic [okvt_pkg::FIELD_W-1:0]  req_value;
    logic [okvt_pkg::POS_W-1:0]    position;

    modport source (output valid, kind, req_key, req_value, position, input ready);
    modport sink   (input valid, kind, req_key, req_value, position, output ready);
endinterface

@@ sv/okvt_rsp_if.sv @@
// Result channel of the ordered key/value table.
// Depends on okvt_pkg for field widths.
interface okvt_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          ok;
    logic [okvt_pkg::FIELD_W-1:0]  out_key;
    logic [okvt_pkg::FIELD_W-1:0]  out_value;
    logic [okvt_pkg::COUNT_W-1:0]  entry_count;

    modport source (output valid, ok, out_key, out_value, entry_count, input ready);
    modport sink   (input valid, ok, out_key, out_value, entry_count, output ready);
endinterface

@@ sv/okvt_cell.sv @@
// One slot of the table: stored key and value, key compare, neighbor shift.
// Depends on okvt_pkg for the cell control struct.
module okvt_cell #(
    parameter int CW  = 5,
    parameter int IW  = 4,
    parameter int IDX = 0,
    parameter int KS  = 32,
    parameter int VS  = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  okvt_pkg::t_cell_ctrl   i_ctrl,
    input  logic [CW-1:0]          i_count,
    input  logic [IW-1:0]          i_at,
    input  logic [KS-1:0]          i_key,
    input  logic [VS-1:0]          i_value,
    input  logic [KS-1:0]          i_next_key,
    input  logic [VS-1:0]          i_next_value,
    output logic [KS-1:0]          o_key,
    output logic [VS-1:0]          o_value,
    output logic                   o_match
);
    import okvt_pkg::*;

    localparam logic [CW-1:0] MY_POS = CW'(IDX);
    localparam logic [IW-1:0] MY_IX  = IW'(IDX);

    logic [KS-1:0] r_key;
    logic [VS-1:0] r_value;
    logic          r_match;
    logic          w_occ;

    assign w_occ = MY_POS < i_count;

    // match flag holds until the next compare so a stalled execute still sees it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= 1'b0;
        end else if (i_ctrl.cmp) begin
            r_match <= w_occ & (r_key == i_key);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.app && MY_POS == i_count) begin
            r_key   <= i_key;
            r_value <= i_value;
        end else if (i_ctrl.upd && r_match) begin
            r_value <= i_value;
        end else if (i_ctrl.ers && MY_IX >= i_at) begin
            r_key   <= i_next_key;
            r_value <= i_next_value;
        end
    end

    assign o_key   = r_key;
    assign o_value = r_value;
    assign o_match = r_match;

endmodule

@@ sv/ordered_key_value_table.sv @@
// Ordered key/value table: top level, request sequencer and row of slot cells.
// Depends on okvt_pkg, okvt_req_if, okvt_rsp_if and okvt_cell.
//
// Usage:
//   i_req carries one request word: kind, req_key, req_value, position.
//   o_rsp carries one result word per request: ok, out_key, out_value and
//   entry_count (entries held after the operation).
//   A request is taken when i_req.valid and i_req.ready are both high.
//   Every slot compares its key in parallel in the cycle after acceptance,
//   the match flags are registered, and in the execute state the slots apply the
//   insert, update or erase (erase shifts upper slots down by one) while the
//   result word is loaded into the output register.
//   Requests pass through the idle, match and execute states; a new request
//   is taken only after the previous one has left the execute state.
//   If o_rsp.ready is low, the result waits in the output register; a new
//   request may still be taken, and its update waits until the old word leaves.
//   Reset empties the table (entry count zero); slot contents are not cleared.
module ordered_key_value_table #(
    parameter int CAPACITY   = 16,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    okvt_req_if.sink   i_req,
    okvt_rsp_if.source o_rsp
);
    import okvt_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);
    localparam int KS = (KEY_BITS < FIELD_W) ? KEY_BITS : FIELD_W;
    localparam int VS = (VALUE_BITS < FIELD_W) ? VALUE_BITS : FIELD_W;
    localparam int PW = (CW > POS_W) ? CW : POS_W;
    localparam int EW = (CW > COUNT_W) ? CW : COUNT_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MATCH,
        S_EXEC
    } t_state;

    t_state               r_state;
    t_kind                r_kind;
    logic [KS-1:0]        r_key;
    logic [VS-1:0]        r_value;
    logic [POS_W-1:0]     r_pos;
    logic [CW-1:0]        r_count;
    logic [CW-1:0]        n_count;
    logic                 r_out_valid;
    logic                 r_ok;
    logic [FIELD_W-1:0]   r_okey;
    logic [FIELD_W-1:0]   r_oval;
    logic [COUNT_W-1:0]   r_ecount;

    logic                 w_fire;
    logic                 w_ok;
    logic                 w_found;
    logic                 w_full;
    logic                 w_pos_ok;
    logic [IW-1:0]        w_at;
    logic [VS-1:0]        w_sel_val;
    logic [KS-1:0]        w_pos_key;
    logic [VS-1:0]        w_pos_val;
    logic [FIELD_W-1:0]   w_okey;
    logic [FIELD_W-1:0]   w_oval;
    logic [EW-1:0]        w_cnt_ext;
    logic [PW-1:0]        w_pos_ext;
    logic [PW-1:0]        w_cntp_ext;
    t_cell_ctrl           w_ctrl;

    logic [KS-1:0]        w_cell_key   [CAPACITY];
    logic [VS-1:0]        w_cell_val   [CAPACITY];
    logic [CAPACITY-1:0]  w_match;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [KS-1:0] w_nk;
        logic [VS-1:0] w_nv;
        if (g == CAPACITY - 1) begin : g_last
            assign w_nk = w_cell_key[g];
            assign w_nv = w_cell_val[g];
        end else begin : g_mid
            assign w_nk = w_cell_key[g+1];
            assign w_nv = w_cell_val[g+1];
        end
        okvt_cell #(
            .CW  (CW),
            .IW  (IW),
            .IDX (g),
            .KS  (KS),
            .VS  (VS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (w_ctrl),
            .i_count      (r_count),
            .i_at         (w_at),
            .i_key        (r_key),
            .i_value      (r_value),
            .i_next_key   (w_nk),
            .i_next_value (w_nv),
            .o_key        (w_cell_key[g]),
            .o_value      (w_cell_val[g]),
            .o_match      (w_match[g])
        );
    end

    assign w_fire = (r_state == S_EXEC) && (!r_out_valid || o_rsp.ready);
    assign w_full = r_count == CW'(CAPACITY);

    // Match and position select over the slot row (at most one key match).
    always_comb begin
        w_pos_ext  = '0;
        w_pos_ext[POS_W-1:0] = r_pos;
        w_cntp_ext = '0;
        w_cntp_ext[CW-1:0] = r_count;
        w_pos_ok   = w_pos_ext < w_cntp_ext;
        w_found    = 1'b0;
        w_at       = '0;
        w_sel_val  = '0;
        w_pos_key  = '0;
        w_pos_val  = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            w_found   = w_found | w_match[i];
            w_at      = w_at | (w_match[i] ? IW'(i) : '0);
            w_sel_val = w_sel_val | (w_match[i] ? w_cell_val[i] : '0);
            if (w_pos_ext == PW'(i)) begin
                w_pos_key = w_pos_key | w_cell_key[i];
                w_pos_val = w_pos_val | w_cell_val[i];
            end
        end
    end

    // Operation decode for the execute cycle; also raises the compare in the match state.
    always_comb begin
        w_ctrl     = '0;
        w_ctrl.cmp = r_state == S_MATCH;
        w_ok       = 1'b0;
        n_count    = r_count;
        w_okey     = '0;
        w_oval     = '0;
        unique case (r_kind)
            K_CONTAINS: begin
                w_ok = w_found;
            end
            K_INSERT, K_INSERT_UPD: begin
                if (w_found) begin
                    if (r_kind == K_INSERT_UPD) begin
                        w_ctrl.upd = w_fire;
                        w_ok       = 1'b1;
                    end
                end else if (!w_full) begin
                    w_ctrl.app = w_fire;
                    n_count    = r_count + CW'(1);
                    w_ok       = 1'b1;
                end
            end
            K_UPDATE: begin
                w_ctrl.upd = w_fire & w_found;
                w_ok       = w_found;
            end
            K_ERASE: begin
                if (w_found) begin
                    w_ctrl.ers = w_fire;
                    n_count    = r_count - CW'(1);
                    w_ok       = 1'b1;
                end
            end
            K_GET_KEY: begin
                w_ok = w_found;
                w_oval[VS-1:0] = w_found ? w_sel_val : '0;
            end
            K_GET_POS: begin
                w_ok = w_pos_ok;
                w_okey[KS-1:0] = w_pos_ok ? w_pos_key : '0;
                w_oval[VS-1:0] = w_pos_ok ? w_pos_val : '0;
            end
            K_CLEAR: begin
                n_count = '0;
                w_ok    = 1'b1;
            end
            default: begin
                w_ok = 1'b0;
            end
        endcase
        w_cnt_ext = '0;
        w_cnt_ext[CW-1:0] = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_state <= S_MATCH;
                    end
                end
                S_MATCH: begin
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    if (w_fire) begin
                        r_state <= S_IDLE;
                        r_count <= n_count;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_req.valid) begin
            r_kind  <= t_kind'(i_req.kind);
            r_key   <= i_req.req_key[KS-1:0];
            r_value <= i_req.req_value[VS-1:0];
            r_pos   <= i_req.position;
        end
        if (w_fire) begin
            r_ok     <= w_ok;
            r_okey   <= w_okey;
            r_oval   <= w_oval;
            r_ecount <= w_cnt_ext[COUNT_W-1:0];
        end
    end

    assign i_req.ready       = r_state == S_IDLE;
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.ok          = r_ok;
    assign o_rsp.out_key     = r_okey;
    assign o_rsp.out_value   = r_oval;
    assign o_rsp.entry_count = r_ecount;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_single_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EXEC |-> $onehot0(w_match))
        else $error("key present in more than one slot");

    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_EXEC))
        else $error("result word without execute cycle");

    a_erase_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_kind == K_ERASE && w_found) |=> r_count == $past(r_count) - CW'(1))
        else $error("erase did not drop entry count");
`endif

endmodule

@@ test/testbench.sv @@
// Testbench for ordered_key_value_table: a directed table of requests, then weighted random
// requests on a small key pool; each result is checked against a shadow table or its typed row.
// Depends on okvt_pkg, okvt_req_if, okvt_rsp_if and the ordered_key_value_table RTL.
module testbench;
    import okvt_pkg::*;

    localparam int SLOTS         = 16;
    localparam int DIRECTED_ROWS = 23;
    localparam int RANDOM_WORDS  = 1415;
    localparam int QUIET_WORDS   = 150;
    localparam int POOL_DEPTH    = 40;
    localparam int PRESSURE_AT   = 300;
    localparam int PRESSURE_LEN  = 120;
    localparam int DRAIN_CYCLES  = 8;
    localparam int CYCLE_LIMIT   = 200000;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] key;
        logic [31:0] value;
        logic [3:0]  pos;
    } t_request;

    typedef struct packed {
        logic        ok;
        logic [31:0] key;
        logic [31:0] value;
        logic [4:0]  count;
    } t_result;

    // reps > 1 repeats the row with the key counting up; typed rows carry their own result
    typedef struct packed {
        t_kind       kind;
        logic [31:0] key;
        logic [31:0] value;
        logic [3:0]  pos;
        logic [4:0]  reps;
        logic        typed;
        logic        ok;
        logic [31:0] out_key;
        logic [31:0] out_value;
        logic [4:0]  count;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    okvt_req_if req_ch ();
    okvt_rsp_if rsp_ch ();

    ordered_key_value_table dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    logic [31:0] shadow_keys [SLOTS];
    logic [31:0] shadow_vals [SLOTS];
    int          shadow_count = 0;
    t_result     pending_results [$];
    logic [31:0] key_pool [POOL_DEPTH];
    int          errors = 0;
    int          results_seen = 0;
    int          cycle_count = 0;
    int          stall_left = 0;
    int          hold_left = 0;
    bit          pressure_done = 1'b0;
    bit          quiet_tail = 1'b0;

    t_row directed_rows [DIRECTED_ROWS] = '{
        '{K_GET_POS,    32'h00000000, 32'h00000000, 4'd0,  5'd1,  1'b1, 1'b0, '0, '0, 5'd0},
        '{K_CONTAINS,   32'h00000000, 32'h00000000, 4'd0,  5'd1,  1'b1, 1'b0, '0, '0, 5'd0},
        '{K_INSERT,     32'h00000000, 32'h00000000, 4'd0,  5'd1,  1'b1, 1'b1, '0, '0, 5'd1},
        '{K_INSERT,     32'hFFFFFFFF, 32'hFFFFFFFF, 4'd15, 5'd1,  1'b1, 1'b1, '0, '0, 5'd2},
        '{K_INSERT,     32'h00000000, 32'h00000001, 4'd0,  5'd1,  1'b1, 1'b0, '0, '0, 5'd2},
        '{K_GET_POS,    32'h00000000, 32'h00000000, 4'd1,  5'd1,  1'b1, 1'b1,
          32'hFFFFFFFF, 32'hFFFFFFFF, 5'd2},
        '{K_UPDATE,     32'hFFFFFFFF, 32'hAAAAAAAA, 4'd0,  5'd1,  1'b0, '0, '0, '0, '0},
        '{K_INSERT_UPD, 32'h00000000, 32'h55555555, 4'd0,  5'd1,  1'b0, '0, '0, '0, '0},
        '{K_ERASE,      32'h00000000, 32'h00000000, 4'd0,  5'd1,  1'b0, '0, '0, '0, '0},
        '{K_GET_KEY,    32'hFFFFFFFF, 32'h00000000, 4'd0,  5'd1,  1'b0, '0, '0, '0, '0},
        '{K_UPDATE,     32'h00000007, 32'h12345678, 4'd0,  5'd1,  1'b1, 1'b0, '0, '0, 5'd1},
        '{K_ERASE,      32'h00000007, 32'h00000000, 4'd0,  5'd1,  1'b1, 1'b0, '0, '0, 5'd1},
        '{K_GET_KEY,    32'h00000007, 32'h00000000, 4'd0,  5'd1,  1'b1, 1'b0, '0, '0, 5'd1},
        '{K_INSERT_UPD, 32'h80000000, 32'h12345678, 4'd0,  5'd15, 1'b0, '0, '0, '0, '0},
        '{K_INSERT,     32'h00000001, 32'h00000001, 4'd0,  5'd1,  1'b1, 1'b0, '0, '0, 5'd16},
        '{K_INSERT_UPD, 32'h00000002, 32'h00000002, 4'd0,  5'd1,  1'b1, 1'b0, '0, '0, 5'd16},
        '{K_CONTAINS,   32'h80000003, 32'h00000000, 4'd0,  5'd1,  1'b0, '0, '0, '0, '0},
        '{K_GET_POS,    32'h00000000, 32'h00000000, 4'd15, 5'd1,  1'b0, '0, '0, '0, '0},
        '{K_ERASE,      32'h80000007, 32'h00000000, 4'd0,  5'd1,  1'b0, '0, '0, '0, '0},
        '{K_GET_POS,    32'h00000000, 32'h00000000, 4'd15, 5'd1,  1'b0, '0, '0, '0, '0},
        '{K_INSERT_UPD, 32'h80000000, 32'hDEADBEEF, 4'd0,  5'd1,  1'b0, '0, '0, '0, '0},
        '{K_CLEAR,      32'h00000000, 32'h00000000, 4'd0,  5'd1,  1'b1, 1'b1, '0, '0, 5'd0},
        '{K_CLEAR,      32'h00000000, 32'h00000000, 4'd0,  5'd1,  1'b1, 1'b1, '0, '0, 5'd0}
    };

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Applies one request to the shadow table and returns the result word it gives.
    function automatic t_result apply_request(input t_request r);
        t_result res;
        int      at;
        int      n;
        bit      found;
        res = '0;
        at  = shadow_count;
        for (n = 0; n < shadow_count; n++)
            if (at == shadow_count && shadow_keys[n] == r.key)
                at = n;
        found = at < shadow_count;
        case (r.kind)
            K_CONTAINS: res.ok = found;
            K_INSERT, K_INSERT_UPD: begin
                if (found) begin
                    if (r.kind == K_INSERT_UPD) begin
                        shadow_vals[at] = r.value;
                        res.ok = 1'b1;
                    end
                end else if (shadow_count < SLOTS) begin
                    shadow_keys[shadow_count] = r.key;
                    shadow_vals[shadow_count] = r.value;
                    shadow_count++;
                    res.ok = 1'b1;
                end
            end
            K_UPDATE: begin
                if (found) begin
                    shadow_vals[at] = r.value;
                    res.ok = 1'b1;
                end
            end
            K_ERASE: begin
                if (found) begin
                    for (n = at; n + 1 < shadow_count; n++) begin
                        shadow_keys[n] = shadow_keys[n + 1];
                        shadow_vals[n] = shadow_vals[n + 1];
                    end
                    shadow_count--;
                    res.ok = 1'b1;
                end
            end
            K_GET_KEY: begin
                if (found) begin
                    res.value = shadow_vals[at];
                    res.ok    = 1'b1;
                end
            end
            K_GET_POS: begin
                if (r.pos < shadow_count) begin
                    res.key   = shadow_keys[r.pos];
                    res.value = shadow_vals[r.pos];
                    res.ok    = 1'b1;
                end
            end
            K_CLEAR: begin
                shadow_count = 0;
                res.ok = 1'b1;
            end
            default: ;
        endcase
        res.count = shadow_count[4:0];
        return res;
    endfunction

    // Offers one word and waits for it to be taken; then records what it should return.
    task automatic offer(input t_request r, input logic typed, input t_result typed_want);
        t_result predicted;
        req_ch.valid     <= 1'b1;
        req_ch.kind      <= r.kind;
        req_ch.req_key   <= r.key;
        req_ch.req_value <= r.value;
        req_ch.position  <= r.pos;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        predicted = apply_request(r);
        pending_results.push_back(typed ? typed_want : predicted);
    endtask

    task automatic maybe_pause();
        int n;
        if (!quiet_tail && $urandom_range(99) < 12) begin
            n = $urandom_range(14, 1);
            req_ch.valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic report(input string field, input logic [31:0] want, input logic [31:0] got);
        errors++;
        $display("%0t: %s mismatch: expected %h actual %h", $time, field, want, got);
    endtask

    task automatic check_word();
        t_result got;
        t_result want;
        got = '{rsp_ch.ok, rsp_ch.out_key, rsp_ch.out_value, rsp_ch.entry_count};
        results_seen++;
        if (pending_results.size() == 0) begin
            report("unexpected word", 32'h0, {31'h0, got.ok});
        end else begin
            want = pending_results.pop_front();
            if (got.ok !== want.ok)
                report("ok", 32'(want.ok), 32'(got.ok));
            if (got.key !== want.key)
                report("out_key", want.key, got.key);
            if (got.value !== want.value)
                report("out_value", want.value, got.value);
            if (got.count !== want.count)
                report("entry_count", 32'(want.count), 32'(got.count));
        end
    endtask

    initial begin
        t_request r;
        t_result  w;
        int       i;
        int       j;
        int       pick;
        int       pool_size;
        i_rst_n          = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.kind      = K_CONTAINS;
        req_ch.req_key   = '0;
        req_ch.req_value = '0;
        req_ch.position  = '0;
        pool_size        = 4;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (i = 0; i < DIRECTED_ROWS; i++) begin
            for (j = 0; j < directed_rows[i].reps; j++) begin
                r = '{directed_rows[i].kind, directed_rows[i].key + j,
                      directed_rows[i].value, directed_rows[i].pos};
                w = '{directed_rows[i].ok, directed_rows[i].out_key,
                      directed_rows[i].out_value, directed_rows[i].count};
                maybe_pause();
                offer(r, directed_rows[i].typed, w);
            end
        end

        for (i = 0; i < RANDOM_WORDS; i++) begin
            // new key pool now and then, with a varying size so the table sometimes fills
            if (i % 100 == 0) begin
                pool_size = $urandom_range(POOL_DEPTH, 4);
                foreach (key_pool[p])
                    key_pool[p] = $urandom;
            end
            if (i == RANDOM_WORDS - QUIET_WORDS)
                quiet_tail = 1'b1;
            pick = $urandom_range(99);
            if (pick < 10)      r.kind = K_CONTAINS;
            else if (pick < 32) r.kind = K_INSERT;
            else if (pick < 42) r.kind = K_UPDATE;
            else if (pick < 60) r.kind = K_INSERT_UPD;
            else if (pick < 74) r.kind = K_ERASE;
            else if (pick < 86) r.kind = K_GET_KEY;
            else if (pick < 99) r.kind = K_GET_POS;
            else                r.kind = K_CLEAR;
            if ($urandom_range(9) == 0)
                r.key = $urandom;
            else
                r.key = key_pool[$urandom_range(pool_size - 1)];
            r.value = $urandom;
            r.pos   = 4'($urandom_range(15));
            maybe_pause();
            offer(r, 1'b0, '0);
        end

        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("[ordered_key_value_table] OK");
        else
            $display("[ordered_key_value_table] ERROR");
        $finish;
    end

    // Result side: check the word taken at this edge, then pick the next ready.
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            check_word();
        if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
        end else if (!pressure_done && results_seen >= PRESSURE_AT) begin
            pressure_done = 1'b1;
            hold_left = PRESSURE_LEN - 1;
            rsp_ch.ready <= 1'b0;
        end else if (quiet_tail) begin
            rsp_ch.ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
        end else if ($urandom_range(99) < 8) begin
            stall_left = $urandom_range(14, 1) - 1;
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[ordered_key_value_table] ERROR");
            $finish;
        end
    end

endmodule

@@ ordered_key_value_table.f @@
sv/okvt_pkg.sv
sv/okvt_req_if.sv
sv/okvt_rsp_if.sv
sv/okvt_cell.sv
sv/ordered_key_value_table.sv
test/testbench.sv
